// File: design/fnss_pkg.sv
// Shared types and constants for the four-neighbour sum stencil.
// No dependencies; imported by every module of the block but fnss_ram.
`default_nettype none

package fnss_pkg;

  // Default largest matrix side
  localparam int MAX_SIDE_DEF = 64;

  // Field widths fixed by the stream format
  localparam int SIDE_W       = 7;
  localparam int SAMPLE_W     = 32;
  localparam int SUM_W        = 34;
  localparam int OUT_TDATA_W  = 40;

  // Side length after reset
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd8;

  // Output buffer entries (power of two, pointers wrap naturally)
  localparam int OBUF_DEPTH   = 4;

  // Item kinds carried on tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  // Per-item control passed from the sequencer to the adder pipeline
  typedef struct packed {
    logic result;    // item yields a result
    logic up_ok;     // upper neighbour exists
    logic down_ok;   // lower neighbour exists (carried by this item)
    logic left_ok;   // left neighbour exists
    logic right_ok;  // right neighbour exists
    logic last;      // result for the final element of the frame
  } fnss_tag_t;

endpackage

`default_nettype wire

// File: design/four_neighbour_sum_stencil.sv
// Four-neighbour sum stencil over a square matrix streamed row by row.
// Throughput: one item per cycle while the output buffer has room; the result for element k
// is formed once the item carrying element k+n is accepted (store read, pair add, final add).
// Rate is set by the line stores, each read and written once per item.
// Reset: side length 8, frame restarts, output buffer empty; store contents undefined.
`default_nettype none

module four_neighbour_sum_stencil
  import fnss_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [SIDE_W-1:0]      cfg_wdata,     // side_length
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [SAMPLE_W-1:0]    s_tdata,       // [31:0] sample
  input  wire logic                   s_tuser,       // [0] action
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,       // [33:0] neighbour_sum, rest zero
  output logic                        m_tlast        // last_of_frame
);

  localparam int LP_W = $clog2(MAX_SIDE);
  localparam int UP_W = $clog2(2 * MAX_SIDE);

  logic                       acc;
  logic                       take;
  logic [LP_W-1:0]            lp_addr;
  logic [UP_W-1:0]            up_addr;
  fnss_tag_t                  tag;
  logic signed [SAMPLE_W-1:0] down_val;
  logic [SAMPLE_W-1:0]        line_q;
  logic [SAMPLE_W-1:0]        up_q;
  logic                       res_valid;
  logic signed [SUM_W-1:0]    res_sum;
  logic                       res_last;
  logic [1:0]                 pending;
  logic                       room;
  logic signed [SUM_W-1:0]    m_sum;

  assign acc      = s_tvalid && s_tready;
  assign s_tready = room;

  fnss_ctrl #(
    .MAX_SIDE (MAX_SIDE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .action    (s_tuser),
    .sample    (s_tdata),
    .take      (take),
    .lp_addr   (lp_addr),
    .up_addr   (up_addr),
    .tag       (tag),
    .down_val  (down_val)
  );

  // Delay of n-1 items: gives the right neighbour
  fnss_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk   (clk),
    .we    (take),
    .waddr (lp_addr),
    .wdata (s_tdata),
    .re    (take),
    .raddr (lp_addr),
    .rdata (line_q)
  );

  // Delay of 2n items: gives the upper neighbour
  fnss_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (2 * MAX_SIDE)
  ) u_up_ram (
    .clk   (clk),
    .we    (take),
    .waddr (up_addr),
    .wdata (s_tdata),
    .re    (take),
    .raddr (up_addr),
    .rdata (up_q)
  );

  fnss_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .tag       (tag),
    .down_val  (down_val),
    .line_q    (line_q),
    .up_q      (up_q),
    .out_valid (res_valid),
    .out_sum   (res_sum),
    .out_last  (res_last),
    .pending   (pending)
  );

  fnss_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_sum  (res_sum),
    .push_last (res_last),
    .pending   (pending),
    .room      (room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_sum     (m_sum),
    .m_last    (m_tlast)
  );

  assign m_tdata = {{(OUT_TDATA_W - SUM_W){1'b0}}, m_sum};

endmodule

`default_nettype wire

// File: design/fnss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address read and write. No dependencies.
`default_nettype none

module fnss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read old contents, then write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: design/fnss_ctrl.sv
// Frame sequencer: side register, row/column tracking and line store pointers.
// Depends on fnss_pkg.
`default_nettype none

module fnss_ctrl
  import fnss_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int COL_W = $clog2(MAX_SIDE),
  localparam int LP_W  = $clog2(MAX_SIDE),
  localparam int UP_W  = $clog2(2 * MAX_SIDE)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [SIDE_W-1:0]          cfg_wdata,
  input  wire logic                       acc,
  input  wire logic                       action,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic                            take,
  output logic      [LP_W-1:0]            lp_addr,
  output logic      [UP_W-1:0]            up_addr,
  output fnss_tag_t                       tag,
  output logic signed [SAMPLE_W-1:0]      down_val
);

  localparam int N_W   = $clog2(MAX_SIDE + 1);
  localparam int CMP_W = N_W + SIDE_W;

  logic [SIDE_W-1:0] side_length;
  logic              filling, filling_next;
  logic [COL_W-1:0]  col, col_next;
  logic [COL_W-1:0]  row, row_next;
  logic [LP_W-1:0]   lp, lp_next;
  logic [UP_W-1:0]   up, up_next;

  logic [CMP_W-1:0]  side_ext;
  logic [N_W-1:0]    n;
  logic [COL_W-1:0]  n_m1;
  logic [LP_W-1:0]   lp_last;
  logic [UP_W-1:0]   up_last;
  logic              drain;
  logic              col_end;

  // Clamp side length into the supported range
  always_comb begin
    side_ext = CMP_W'(side_length);
    if (side_ext < CMP_W'(2)) begin
      n = N_W'(2);
    end else if (side_ext > CMP_W'(MAX_SIDE)) begin
      n = N_W'(MAX_SIDE);
    end else begin
      n = N_W'(side_length);
    end
    n_m1    = COL_W'(n - N_W'(1));
    lp_last = LP_W'(n - N_W'(2));
    up_last = UP_W'({n, 1'b0} - (N_W + 1)'(1));
  end

  // Classify the item and advance frame position
  always_comb begin
    drain   = !filling && (row == n_m1);
    col_end = (col == n_m1);
    take    = acc && !((action == ACT_FLUSH) && !drain);

    tag.result   = !filling;
    tag.up_ok    = (row != '0);
    tag.down_ok  = !drain;
    tag.left_ok  = (col != '0);
    tag.right_ok = !col_end;
    tag.last     = drain && col_end;

    // drop the value of a late sample
    down_val = drain ? '0 : sample;

    filling_next = filling;
    col_next     = col;
    row_next     = row;
    lp_next      = lp;
    up_next      = up;

    if (take) begin
      lp_next = (lp == lp_last) ? '0 : lp + LP_W'(1);
      up_next = (up == up_last) ? '0 : up + UP_W'(1);
      if (col_end) begin
        col_next = '0;
        if (filling) begin
          filling_next = 1'b0;
          row_next     = '0;
        end else if (row == n_m1) begin
          // frame done: restart
          filling_next = 1'b1;
          row_next     = '0;
          lp_next      = '0;
          up_next      = '0;
        end else begin
          row_next = row + COL_W'(1);
        end
      end else begin
        col_next = col + COL_W'(1);
      end
    end

    // a side write restarts the frame
    if (cfg_we) begin
      filling_next = 1'b1;
      col_next     = '0;
      row_next     = '0;
      lp_next      = '0;
      up_next      = '0;
    end
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      side_length <= SIDE_RESET;
      filling     <= 1'b1;
      col         <= '0;
      row         <= '0;
      lp          <= '0;
      up          <= '0;
    end else begin
      if (cfg_we) begin
        side_length <= cfg_wdata;
      end
      filling <= filling_next;
      col     <= col_next;
      row     <= row_next;
      lp      <= lp_next;
      up      <= up_next;
    end
  end

  assign lp_addr = lp;
  assign up_addr = up;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (col <= n_m1) && (row <= n_m1))
    else $error("frame position beyond matrix side");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    take && tag.last |=> filling && (col == '0) && (lp == '0) && (up == '0))
    else $error("frame did not restart after its last result");
`endif

endmodule

`default_nettype wire

// File: design/fnss_sum.sv
// Adder pipeline: neighbour window registers and two-level masked sum.
// Depends on fnss_pkg; fed by fnss_ctrl and the two line stores.
`default_nettype none

module fnss_sum
  import fnss_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take,
  input  wire fnss_tag_t                  tag,
  input  wire logic signed [SAMPLE_W-1:0] down_val,
  input  wire logic signed [SAMPLE_W-1:0] line_q,
  input  wire logic signed [SAMPLE_W-1:0] up_q,
  output logic                            out_valid,
  output logic signed [SUM_W-1:0]         out_sum,
  output logic                            out_last,
  output logic      [1:0]                 pending
);

  logic                         took1;
  fnss_tag_t                    tag1;
  logic signed [SAMPLE_W-1:0]   down1;
  logic signed [SAMPLE_W-1:0]   kreg;
  logic signed [SAMPLE_W-1:0]   km1;

  logic signed [SAMPLE_W-1:0]   left_v, right_v, up_v, down_v;
  logic signed [SAMPLE_W:0]     pa, pb;

  logic                         v2;
  logic                         last2;
  logic signed [SAMPLE_W:0]     pa2, pb2;

  // Capture item control alongside the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      took1 <= 1'b0;
      v2    <= 1'b0;
    end else begin
      took1 <= take;
      v2    <= took1 && tag1.result;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tag1  <= tag;
      down1 <= down_val;
    end
  end

  // Shift the row window: line_q is the right neighbour, kreg the centre
  always_ff @(posedge clk) begin
    if (took1) begin
      km1  <= kreg;
      kreg <= line_q;
    end
  end

  // Mask missing neighbours and form pair sums
  always_comb begin
    left_v  = tag1.left_ok  ? km1    : '0;
    right_v = tag1.right_ok ? line_q : '0;
    up_v    = tag1.up_ok    ? up_q   : '0;
    down_v  = tag1.down_ok  ? down1  : '0;
    pa = (SAMPLE_W + 1)'(left_v) + (SAMPLE_W + 1)'(right_v);
    pb = (SAMPLE_W + 1)'(up_v)   + (SAMPLE_W + 1)'(down_v);
  end

  always_ff @(posedge clk) begin
    if (took1) begin
      pa2   <= pa;
      pb2   <= pb;
      last2 <= tag1.last;
    end
  end

  // Final add into the output buffer
  assign out_valid = v2;
  assign out_sum   = SUM_W'(pa2) + SUM_W'(pb2);
  assign out_last  = last2;
  assign pending   = {1'b0, took1 && tag1.result} + {1'b0, v2};

endmodule

`default_nettype wire

// File: design/fnss_obuf.sv
// Output buffer holding finished results, with credit for items in flight.
// Depends on fnss_pkg.
`default_nettype none

module fnss_obuf
  import fnss_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire logic signed [SUM_W-1:0] push_sum,
  input  wire logic                    push_last,
  input  wire logic [1:0]              pending,
  output logic                         room,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic signed [SUM_W-1:0]      m_sum,
  output logic                         m_last
);

  localparam int PTR_W = $clog2(OBUF_DEPTH);
  localparam int CNT_W = $clog2(OBUF_DEPTH + 1);

  logic signed [SUM_W-1:0] sum_mem [OBUF_DEPTH];
  logic                    last_mem [OBUF_DEPTH];
  logic [PTR_W-1:0]        wp, rp;
  logic [CNT_W-1:0]        count;
  logic                    pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (count != '0);
  assign m_sum    = sum_mem[rp];
  assign m_last   = last_mem[rp];

  // Accept a new item only if every result in flight has a slot
  assign room = ((CNT_W + 1)'(count) + (CNT_W + 1)'(pending))
                < (CNT_W + 1)'(OBUF_DEPTH);

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      sum_mem[wp]  <= push_sum;
      last_mem[wp] <= push_last;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + PTR_W'(1);
      end
      if (pop) begin
        rp <= rp + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(OBUF_DEPTH)) || pop)
    else $error("result pushed into a full buffer");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    ((CNT_W + 1)'(count) + (CNT_W + 1)'(pending)) <= (CNT_W + 1)'(OBUF_DEPTH))
    else $error("results in flight exceed buffer space");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for four_neighbour_sum_stencil: a directed table of edge cases,
// then random frames at many side lengths, checked against a neighbour-sum predictor.
// Depends on fnss_pkg and the four_neighbour_sum_stencil RTL only.

module tb_top;
  import fnss_pkg::*;

  localparam int RING_DEPTH     = 2 * MAX_SIDE_DEF + 1;
  localparam int PIPE_LAT       = 3;
  localparam int ITEM_TARGET    = 1700;
  localparam int FULL_FRAME_MAX = 12;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int DIR_ROWS       = 27;

  localparam logic [SAMPLE_W-1:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] S_MIN = 32'h8000_0000;
  localparam logic [SUM_W-1:0] SUM_TWO_MAX  = 34'h0_FFFF_FFFE;
  localparam logic [SUM_W-1:0] SUM_TWO_MIN  = 34'h3_0000_0000;
  localparam logic [SUM_W-1:0] SUM_FOUR_MIN = 34'h2_0000_0000;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             last;
  } nsum_t;

  localparam nsum_t NSUM_NONE = '0;

  // One row of the directed table: a side write or an item, with an optional typed result
  typedef struct packed {
    logic              is_cfg;
    logic [SIDE_W-1:0] side;
    logic              act;
    logic [SAMPLE_W-1:0] smp;
    logic              typed;
    logic [SUM_W-1:0]  sum;
    logic              last;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // side 2, all maximum: early flush ignored, late sample acts as flush
    '{1'b1, 7'd2, ACT_SAMPLE, 32'h0,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_FLUSH,  32'h1234_5678, 1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MAX,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MAX,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MAX,         1'b1, SUM_TWO_MAX,  1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MAX,         1'b1, SUM_TWO_MAX,  1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, 32'h5A5A_5A5A, 1'b1, SUM_TWO_MAX,  1'b0},
    '{1'b0, 7'd0, ACT_FLUSH,  32'hFFFF_FFFF, 1'b1, SUM_TWO_MAX,  1'b1},
    // side 2 again, frame restarts by itself, all minimum
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b1, SUM_TWO_MIN,  1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b1, SUM_TWO_MIN,  1'b0},
    '{1'b0, 7'd0, ACT_FLUSH,  32'h0,         1'b1, SUM_TWO_MIN,  1'b0},
    '{1'b0, 7'd0, ACT_FLUSH,  32'h0,         1'b1, SUM_TWO_MIN,  1'b1},
    // side 3, all minimum: the centre sees four neighbours, the most negative sum
    '{1'b1, 7'd3, ACT_SAMPLE, 32'h0,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b1, SUM_FOUR_MIN, 1'b0},
    '{1'b0, 7'd0, ACT_SAMPLE, S_MIN,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_FLUSH,  32'h0,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_FLUSH,  32'h0,         1'b0, 34'h0,        1'b0},
    '{1'b0, 7'd0, ACT_FLUSH,  32'h0,         1'b1, SUM_TWO_MIN,  1'b1}
  };

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [SIDE_W-1:0]      cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  // Predictor state: side register, line ring, frame position and ring slot
  logic [SIDE_W-1:0]   side_reg;
  logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  int unsigned         frame_pos;
  int unsigned         ring_slot;

  nsum_t pending_sums [$];

  bit steady;
  int rx_hold;
  int err_count;
  int items_fed;
  int ignored_flushes;
  int sums_checked;
  int frame_ends;
  int side_writes;

  four_neighbour_sum_stencil #(.MAX_SIDE(MAX_SIDE_DEF)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),      // [31:0] sample
    .s_tuser   (s_tuser),      // [0] action
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),      // [33:0] neighbour_sum, [39:34] zero
    .m_tlast   (m_tlast)       // last_of_frame
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp the side register to the range the block works with
  function automatic int unsigned eff_side(input logic [SIDE_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return 32'(v);
  endfunction

  // Ring entry written 'back' items before slot 'cur', sign-extended
  function automatic longint ring_word(input int unsigned cur, input int unsigned back);
    int unsigned slot;
    slot = (cur + RING_DEPTH - (back % RING_DEPTH)) % RING_DEPTH;
    return longint'($signed(ring_mem[slot]));
  endfunction

  // Mostly random words, with the extremes and small values now and then
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Advance the predictor by one accepted item; report whether it counted and its sum
  task automatic stencil_predict(input logic act, input logic [SAMPLE_W-1:0] smp,
                                 output logic taken, output logic has_res,
                                 output nsum_t res);
    int unsigned n, total, pos, cur, k, col;
    logic is_smp;
    longint acc;
    n = eff_side(side_reg);
    total = n * n;
    pos = frame_pos;
    is_smp = (act == ACT_SAMPLE) && (pos < total);
    taken = 1'b0;
    has_res = 1'b0;
    res = NSUM_NONE;
    // flush before the frame is complete: drop
    if (!is_smp && pos < total) return;
    taken = 1'b1;
    cur = ring_slot;
    ring_mem[cur] = is_smp ? smp : '0;
    ring_slot = (cur + 1) % RING_DEPTH;
    frame_pos = pos + 1;
    if (pos < n) return;
    k = pos - n;
    col = k % n;
    acc = 0;
    if (k >= n) acc += ring_word(cur, 2 * n);
    if (k + n < total) acc += ring_word(cur, 0);
    if (col > 0) acc += ring_word(cur, n + 1);
    if (col + 1 < n) acc += ring_word(cur, n - 1);
    has_res = 1'b1;
    res.sum = acc[SUM_W-1:0];
    res.last = (k + 1 == total);
    if (k + 1 == total) begin
      frame_pos = 0;
      ring_slot = 0;
    end
  endtask

  // Offer one item after a random gap; hold it until accepted, then record its sum
  task automatic send_item(input logic act, input logic [SAMPLE_W-1:0] smp,
                           input logic typed, input nsum_t typed_res);
    int gap;
    logic taken, has_res;
    nsum_t res;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = smp;
    do @(posedge clk); while (!s_tready);
    stencil_predict(act, smp, taken, has_res, res);
    if (taken) items_fed++;
    else ignored_flushes++;
    if (has_res) pending_sums.insert(pending_sums.size(), typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Drop valid, wait for every expected sum, then let the pipeline empty
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  // Write the side register; the frame restarts
  task automatic write_side(input logic [SIDE_W-1:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    side_reg = v;
    frame_pos = 0;
    ring_slot = 0;
    side_writes++;
  endtask

  // Output side: random stall before each result
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready = 1'b0;
      end else if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Compare each result with the oldest expected sum
  always @(posedge clk) begin
    nsum_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sums.size() == 0) begin
        err_count++;
        $display("[%0t] unexpected result: expected none, actual sum %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = pending_sums.pop_front();
        if (m_tdata !== {{(OUT_TDATA_W-SUM_W){1'b0}}, want.sum}) begin
          err_count++;
          $display("[%0t] neighbour_sum mismatch: expected %h, actual %h",
                   $time, {{(OUT_TDATA_W-SUM_W){1'b0}}, want.sum}, m_tdata);
        end
        if (m_tlast !== want.last) begin
          err_count++;
          $display("[%0t] last_of_frame mismatch: expected %b, actual %b",
                   $time, want.last, m_tlast);
        end
        if (want.last) frame_ends++;
      end
      sums_checked++;
      rx_hold = steady ? 0 : $urandom_range(0, 8);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[%0t] watchdog: %0d cycles without an item moving", $time, quiet_cycles);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int r, i, f, frames, rows, phase;
    int unsigned n;
    logic [SIDE_W-1:0] side_pick;
    bit cut;
    dir_row_t row;
    nsum_t typed_res;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = ACT_SAMPLE;
    steady = 1'b0;
    rx_hold = 0;
    err_count = 0;
    items_fed = 0;
    ignored_flushes = 0;
    sums_checked = 0;
    frame_ends = 0;
    side_writes = 0;
    side_reg = SIDE_RESET;
    frame_pos = 0;
    ring_slot = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      if (row.is_cfg) begin
        settle();
        write_side(row.side);
      end else begin
        typed_res.sum = row.sum;
        typed_res.last = row.last;
        send_item(row.act, row.smp, row.typed, typed_res);
      end
    end

    // Random phases: one side setting each, extremes first
    phase = 0;
    while (items_fed < ITEM_TARGET) begin
      case (phase)
        0: side_pick = 7'd0;
        1: side_pick = 7'd127;
        2: side_pick = 7'd1;
        3: side_pick = 7'd64;
        4: side_pick = 7'd2;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 70) side_pick = SIDE_W'($urandom_range(2, 8));
          else if (r < 85) side_pick = SIDE_W'($urandom_range(9, 12));
          else if (r < 93) side_pick = SIDE_W'($urandom_range(13, 63));
          else if (r < 96) side_pick = SIDE_W'($urandom_range(0, 1));
          else side_pick = SIDE_W'($urandom_range(64, 127));
        end
      endcase
      settle();
      write_side(side_pick);
      n = eff_side(side_pick);
      steady = ($urandom_range(0, 4) == 0);
      cut = 1'b0;
      if (n > FULL_FRAME_MAX) begin
        // large side: a few rows only, cut short by the next side write
        rows = n * $urandom_range(2, 4) + $urandom_range(0, n - 1);
        for (i = 0; i < rows; i++) begin
          if ($urandom_range(0, 31) == 0) send_item(ACT_FLUSH, $urandom, 1'b0, NSUM_NONE);
          send_item(ACT_SAMPLE, rand_sample(), 1'b0, NSUM_NONE);
        end
      end else begin
        frames = $urandom_range(1, 3);
        for (f = 0; f < frames && !cut; f++) begin
          // samples, with stray early flushes and the odd frame broken off
          for (i = 0; i < n * n; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(ACT_FLUSH, $urandom, 1'b0, NSUM_NONE);
            if (i > 0 && $urandom_range(0, 39) == 0) begin
              cut = 1'b1;
              break;
            end
            send_item(ACT_SAMPLE, rand_sample(), 1'b0, NSUM_NONE);
          end
          // drain the last row; some drain items are late samples
          if (!cut) begin
            for (i = 0; i < n; i++)
              send_item(($urandom_range(0, 3) == 0) ? ACT_SAMPLE : ACT_FLUSH,
                        rand_sample(), 1'b0, NSUM_NONE);
          end
        end
      end
      phase++;
    end

    settle();
    repeat (PIPE_LAT + 8) @(negedge clk);

    $display("Fed %0d items over %0d side writes, %0d early flushes ignored.",
             items_fed, side_writes, ignored_flushes);
    $display("Checked %0d neighbour sums, %0d of them frame ends.", sums_checked, frame_ends);
    if (err_count == 0 && pending_sums.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
design/fnss_pkg.sv
design/fnss_ram.sv
design/fnss_ctrl.sv
design/fnss_sum.sv
design/fnss_obuf.sv
design/four_neighbour_sum_stencil.sv
verif/tb_top.sv
